FILE: rtl/wifi_phy_rate_calculator_assert.svh
// assertion macros shared by the rate calculator rtl
`ifndef WIFI_PHY_RATE_CALCULATOR_ASSERT_SVH
`define WIFI_PHY_RATE_CALCULATOR_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define WPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wpr assertion failed");

// next-cycle implication, checked while out of reset
`define WPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wpr assertion failed");

`endif

FILE: rtl/wpr_pkg.sv
`default_nettype none

package wpr_pkg;

    localparam int MODE_W   = 8;
    localparam int FIELD_W  = 8;
    localparam int LEGACY_W = 16;
    localparam int BASE_W   = 13;
    localparam int MULT_W   = 8;
    localparam int SHIFT_W  = 2;
    localparam int RATE_W   = 21;

    // rate mode codes
    localparam logic [MODE_W-1:0] MODE_LEGACY = 8'd0;
    localparam logic [MODE_W-1:0] MODE_HT     = 8'd1;
    localparam logic [MODE_W-1:0] MODE_VHT    = 8'd2;
    localparam logic [MODE_W-1:0] MODE_HE     = 8'd3;

    // range limits
    localparam logic [FIELD_W-1:0] HT_MCS_MAX  = 8'd31;
    localparam logic [FIELD_W-1:0] VHT_MCS_MAX = 8'd9;
    localparam logic [FIELD_W-1:0] HE_MCS_MAX  = 8'd11;
    localparam logic [FIELD_W-1:0] HT_BW_MAX   = 8'd1;
    localparam logic [FIELD_W-1:0] BW_MAX      = 8'd2;
    localparam logic [FIELD_W-1:0] HE_GI_MAX   = 8'd2;

    // vht rates per stream, [bandwidth][short gi][mcs]; ht reuses mcs 0-7 of 20/40 mhz
    localparam logic [BASE_W-1:0] VHT_RATE [3][2][10] = '{
        '{ '{13'd65,  13'd130, 13'd195, 13'd260, 13'd390,
             13'd520, 13'd585, 13'd650, 13'd780, 13'd0},
           '{13'd72,  13'd144, 13'd217, 13'd289, 13'd433,
             13'd578, 13'd650, 13'd722, 13'd867, 13'd963} },
        '{ '{13'd135, 13'd270, 13'd405, 13'd540, 13'd810,
             13'd1080, 13'd1215, 13'd1350, 13'd1620, 13'd1800},
           '{13'd150, 13'd300, 13'd450, 13'd600, 13'd900,
             13'd1200, 13'd1350, 13'd1500, 13'd1800, 13'd2000} },
        '{ '{13'd293, 13'd585, 13'd878, 13'd1170, 13'd1755,
             13'd2340, 13'd2633, 13'd2925, 13'd3510, 13'd3900},
           '{13'd325, 13'd650, 13'd975, 13'd1300, 13'd1950,
             13'd2600, 13'd2925, 13'd3250, 13'd3900, 13'd4333} }
    };

    // he 20 mhz rates per stream, [gi index][mcs]
    localparam logic [BASE_W-1:0] HE_RATE [3][12] = '{
        '{13'd73, 13'd146, 13'd219, 13'd293, 13'd439, 13'd585,
          13'd658, 13'd731, 13'd878, 13'd975, 13'd1097, 13'd1219},
        '{13'd81, 13'd163, 13'd244, 13'd325, 13'd488, 13'd650,
          13'd731, 13'd813, 13'd975, 13'd1083, 13'd1219, 13'd1354},
        '{13'd86, 13'd172, 13'd258, 13'd344, 13'd516, 13'd688,
          13'd774, 13'd860, 13'd1032, 13'd1147, 13'd1290, 13'd1434}
    };

    // decoded descriptor handed from lookup to scaling
    typedef struct packed {
        logic                in_range;
        logic                legacy;
        logic [LEGACY_W-1:0] legacy_rate;
        logic [BASE_W-1:0]   base;
        logic [MULT_W-1:0]   mult;
        logic [SHIFT_W-1:0]  shift;
    } t_lookup;

endpackage

`default_nettype wire

FILE: rtl/wpr_lookup.sv
`default_nettype none

module wpr_lookup (
    input  wire logic [wpr_pkg::MODE_W-1:0]   i_rate_mode,
    input  wire logic [wpr_pkg::FIELD_W-1:0]  i_mcs_index,
    input  wire logic [wpr_pkg::LEGACY_W-1:0] i_legacy_rate,
    input  wire logic [wpr_pkg::FIELD_W-1:0]  i_stream_count,
    input  wire logic [wpr_pkg::FIELD_W-1:0]  i_bandwidth_code,
    input  wire logic [wpr_pkg::FIELD_W-1:0]  i_guard_code,
    output wpr_pkg::t_lookup                  o_lookup
);

    logic                         sgi;
    logic [wpr_pkg::MULT_W-1:0]   nss;
    logic [wpr_pkg::SHIFT_W-1:0]  bw_idx;
    logic [3:0]                   mcs_idx;
    logic [wpr_pkg::SHIFT_W-1:0]  gi_idx;

    assign sgi     = |i_guard_code;
    assign nss     = (i_stream_count == '0) ? wpr_pkg::MULT_W'(1) : i_stream_count;
    assign bw_idx  = i_bandwidth_code[wpr_pkg::SHIFT_W-1:0];
    assign mcs_idx = i_mcs_index[3:0];
    assign gi_idx  = i_guard_code[wpr_pkg::SHIFT_W-1:0];

    always_comb begin
        o_lookup             = '0;
        o_lookup.legacy_rate = i_legacy_rate;
        unique case (i_rate_mode)
            wpr_pkg::MODE_LEGACY: begin
                o_lookup.in_range = 1'b1;
                o_lookup.legacy   = 1'b1;
            end
            wpr_pkg::MODE_HT: begin
                o_lookup.in_range = (i_mcs_index <= wpr_pkg::HT_MCS_MAX) &&
                                    (i_bandwidth_code <= wpr_pkg::HT_BW_MAX);
                if (o_lookup.in_range) begin
                    o_lookup.base = wpr_pkg::VHT_RATE[bw_idx][sgi][{1'b0, i_mcs_index[2:0]}];
                end
                // streams come from the upper mcs bits
                o_lookup.mult = wpr_pkg::MULT_W'(i_mcs_index[4:3]) + wpr_pkg::MULT_W'(1);
            end
            wpr_pkg::MODE_VHT: begin
                o_lookup.in_range = (i_mcs_index <= wpr_pkg::VHT_MCS_MAX) &&
                                    (i_bandwidth_code <= wpr_pkg::BW_MAX);
                if (o_lookup.in_range) begin
                    o_lookup.base = wpr_pkg::VHT_RATE[bw_idx][sgi][mcs_idx];
                end
                o_lookup.mult = nss;
            end
            wpr_pkg::MODE_HE: begin
                o_lookup.in_range = (i_mcs_index <= wpr_pkg::HE_MCS_MAX) &&
                                    (i_bandwidth_code <= wpr_pkg::BW_MAX) &&
                                    (i_guard_code <= wpr_pkg::HE_GI_MAX);
                if (o_lookup.in_range) begin
                    o_lookup.base = wpr_pkg::HE_RATE[gi_idx][mcs_idx];
                end
                o_lookup.mult  = nss;
                o_lookup.shift = bw_idx;
            end
            default: begin
                o_lookup.in_range = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/wpr_scale.sv
`default_nettype none

module wpr_scale (
    input  wire wpr_pkg::t_lookup           i_lookup,
    output logic [wpr_pkg::RATE_W-1:0]      o_rate
);

    localparam int PROD_W = wpr_pkg::BASE_W + wpr_pkg::MULT_W;
    localparam int WIDE_W = PROD_W + 3;

    logic [PROD_W-1:0] product;
    logic [WIDE_W-1:0] shifted;

    assign product = PROD_W'(i_lookup.base) * PROD_W'(i_lookup.mult);
    assign shifted = WIDE_W'(product) << i_lookup.shift;

    always_comb begin
        if (!i_lookup.in_range) begin
            o_rate = '0;
        end else if (i_lookup.legacy) begin
            o_rate = wpr_pkg::RATE_W'(i_lookup.legacy_rate);
        end else begin
            o_rate = shifted[wpr_pkg::RATE_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/wifi_phy_rate_calculator.sv
// phy transmit bit rate calculator, result in 100 kbps units
// input channel: i_in_valid / o_in_ready, one rate descriptor per beat
// output channel: o_out_valid / i_out_ready, one bit rate per beat
// each beat is a full descriptor; the result of an invalid descriptor is 0
// pipeline: descriptor register, then table lookup + one 13x8 multiply +
//   shift by the bandwidth code for he, then the result register
// throughput: one beat per cycle in both directions while i_out_ready is high
// stall: when the result waits, one more descriptor is held in the input
//   register; o_in_ready drops only when both registers are full
// reset (i_rst_n low, synchronous) empties both registers; no table state
// needs clearing, so the block takes beats as soon as reset is released
`default_nettype none

`include "wifi_phy_rate_calculator_assert.svh"

module wifi_phy_rate_calculator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [wpr_pkg::MODE_W-1:0]      i_rate_mode,
    input  wire logic [wpr_pkg::FIELD_W-1:0]     i_mcs_index,
    input  wire logic [wpr_pkg::LEGACY_W-1:0]    i_legacy_rate,
    input  wire logic [wpr_pkg::FIELD_W-1:0]     i_stream_count,
    input  wire logic [wpr_pkg::FIELD_W-1:0]     i_bandwidth_code,
    input  wire logic [wpr_pkg::FIELD_W-1:0]     i_guard_code,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [wpr_pkg::RATE_W-1:0]           o_bitrate_100kbps
);

    // descriptor register
    logic                            r_s1_valid;
    logic [wpr_pkg::MODE_W-1:0]      r_mode;
    logic [wpr_pkg::FIELD_W-1:0]     r_mcs;
    logic [wpr_pkg::LEGACY_W-1:0]    r_legacy;
    logic [wpr_pkg::FIELD_W-1:0]     r_streams;
    logic [wpr_pkg::FIELD_W-1:0]     r_bw;
    logic [wpr_pkg::FIELD_W-1:0]     r_gi;

    // result register
    logic                            r_out_valid;
    logic [wpr_pkg::RATE_W-1:0]      r_rate;

    logic                            n_s1_valid;
    logic                            n_out_valid;
    logic                            s1_load;
    logic                            s1_adv;
    logic                            out_free;
    wpr_pkg::t_lookup                lookup;
    logic [wpr_pkg::RATE_W-1:0]      rate;

    // result slot opens when empty or being taken this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign s1_load    = i_in_valid && o_in_ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (s1_load) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_mode    <= i_rate_mode;
            r_mcs     <= i_mcs_index;
            r_legacy  <= i_legacy_rate;
            r_streams <= i_stream_count;
            r_bw      <= i_bandwidth_code;
            r_gi      <= i_guard_code;
        end
        if (s1_adv) begin
            r_rate <= rate;
        end
    end

    // decode the descriptor and pick the per-stream rate
    wpr_lookup u_lookup (
        .i_rate_mode      (r_mode),
        .i_mcs_index      (r_mcs),
        .i_legacy_rate    (r_legacy),
        .i_stream_count   (r_streams),
        .i_bandwidth_code (r_bw),
        .i_guard_code     (r_gi),
        .o_lookup         (lookup)
    );

    // streams times base rate, widened by bandwidth for he
    wpr_scale u_scale (
        .i_lookup (lookup),
        .o_rate   (rate)
    );

    assign o_out_valid       = r_out_valid;
    assign o_bitrate_100kbps = r_rate;

    `WPR_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, s1_adv, r_out_valid)
    `WPR_ASSERT_NEXT(a_stall_holds_s1, i_clk, i_rst_n,
        r_out_valid && !i_out_ready && r_s1_valid, r_s1_valid)
    `WPR_ASSERT_NOW(a_busy_means_full, i_clk, i_rst_n,
        !o_in_ready, r_s1_valid && r_out_valid)
    `WPR_ASSERT_NEXT(a_bad_mode_zero, i_clk, i_rst_n,
        s1_adv && (r_mode > wpr_pkg::MODE_HE), o_bitrate_100kbps == '0)

endmodule

`default_nettype wire

FILE: tb/tb_wifi_phy_rate_calculator.sv
`timescale 1ns / 100ps

package tb_rate_pkg;

    typedef struct {
        logic [wpr_pkg::MODE_W-1:0]   rate_mode;
        logic [wpr_pkg::FIELD_W-1:0]  mcs_index;
        logic [wpr_pkg::LEGACY_W-1:0] legacy_rate;
        logic [wpr_pkg::FIELD_W-1:0]  stream_count;
        logic [wpr_pkg::FIELD_W-1:0]  bandwidth_code;
        logic [wpr_pkg::FIELD_W-1:0]  guard_code;
    } t_rate_desc;

    // per-stream rates, [bandwidth][short gi][mcs]; ht uses mcs 0-7 of 20/40 mhz
    localparam int PER_STREAM_VHT [3][2][10] = '{
        '{ '{65, 130, 195, 260, 390, 520, 585, 650, 780, 0},
           '{72, 144, 217, 289, 433, 578, 650, 722, 867, 963} },
        '{ '{135, 270, 405, 540, 810, 1080, 1215, 1350, 1620, 1800},
           '{150, 300, 450, 600, 900, 1200, 1350, 1500, 1800, 2000} },
        '{ '{293, 585, 878, 1170, 1755, 2340, 2633, 2925, 3510, 3900},
           '{325, 650, 975, 1300, 1950, 2600, 2925, 3250, 3900, 4333} }
    };

    // he per-stream rates at 20 mhz, [gi index][mcs]
    localparam int PER_STREAM_HE20 [3][12] = '{
        '{73, 146, 219, 293, 439, 585, 658, 731, 878, 975, 1097, 1219},
        '{81, 163, 244, 325, 488, 650, 731, 813, 975, 1083, 1219, 1354},
        '{86, 172, 258, 344, 516, 688, 774, 860, 1032, 1147, 1290, 1434}
    };

    function automatic logic [wpr_pkg::RATE_W-1:0] phy_rate(t_rate_desc d);
        int nss;
        int sgi;
        int bw;
        int mcs;
        int r;
        nss = (d.stream_count == 0) ? 1 : int'(d.stream_count);
        sgi = (d.guard_code != 0) ? 1 : 0;
        bw  = int'(d.bandwidth_code);
        mcs = int'(d.mcs_index);
        r   = 0;
        case (d.rate_mode)
            wpr_pkg::MODE_LEGACY: r = int'(d.legacy_rate);
            wpr_pkg::MODE_HT: begin
                // stream count comes from the mcs index, stream field ignored
                if (mcs <= 31 && bw <= 1)
                    r = PER_STREAM_VHT[bw][sgi][mcs % 8] * (mcs / 8 + 1);
            end
            wpr_pkg::MODE_VHT: begin
                if (mcs <= 9 && bw <= 2)
                    r = PER_STREAM_VHT[bw][sgi][mcs] * nss;
            end
            wpr_pkg::MODE_HE: begin
                if (mcs <= 11 && bw <= 2 && d.guard_code <= 2)
                    r = (PER_STREAM_HE20[d.guard_code][mcs] * nss) << bw;
            end
            default: r = 0;
        endcase
        return r[wpr_pkg::RATE_W-1:0];
    endfunction

    class rate_scoreboard;
        logic [wpr_pkg::RATE_W-1:0] expected_rates [$];
        int errors;
        int descriptors;
        int rates_checked;

        function new();
            errors        = 0;
            descriptors   = 0;
            rates_checked = 0;
        endfunction

        function void note_descriptor(t_rate_desc d);
            expected_rates.push_back(phy_rate(d));
            descriptors++;
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_rate(logic [wpr_pkg::RATE_W-1:0] got);
            logic [wpr_pkg::RATE_W-1:0] want;
            if (expected_rates.size() == 0) begin
                report($sformatf("rate %0d arrived with no descriptor pending", got));
                return;
            end
            want = expected_rates.pop_front();
            rates_checked++;
            if (got !== want)
                report($sformatf("result beat %0d: rate %0d, expected %0d",
                                 rates_checked, got, want));
        endtask

        function int pending();
            return expected_rates.size();
        endfunction
    endclass
endpackage

module tb_wifi_phy_rate_calculator;

    typedef enum int {
        PH_DIRECTED,
        PH_FREE,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH,
        PH_PRESSURE
    } t_phase;

    localparam int HOLD_OFF_CYCLES = 300;

    logic                              i_clk            = 1'b0;
    logic                              i_rst_n          = 1'b0;
    logic                              i_in_valid       = 1'b0;
    logic                              o_in_ready;
    logic [wpr_pkg::MODE_W-1:0]        i_rate_mode      = '0;
    logic [wpr_pkg::FIELD_W-1:0]       i_mcs_index      = '0;
    logic [wpr_pkg::LEGACY_W-1:0]      i_legacy_rate    = '0;
    logic [wpr_pkg::FIELD_W-1:0]       i_stream_count   = '0;
    logic [wpr_pkg::FIELD_W-1:0]       i_bandwidth_code = '0;
    logic [wpr_pkg::FIELD_W-1:0]       i_guard_code     = '0;
    logic                              o_out_valid;
    logic                              i_out_ready      = 1'b0;
    logic [wpr_pkg::RATE_W-1:0]        o_bitrate_100kbps;

    // receiver knobs; stall_pct and hold_active change only with nonblocking writes at the clock edge
    int     stall_pct   = 0;
    logic   hold_active = 1'b0;
    t_phase phase       = PH_DIRECTED;

    tb_rate_pkg::rate_scoreboard sb;

    wifi_phy_rate_calculator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_rate_mode       (i_rate_mode),
        .i_mcs_index       (i_mcs_index),
        .i_legacy_rate     (i_legacy_rate),
        .i_stream_count    (i_stream_count),
        .i_bandwidth_code  (i_bandwidth_code),
        .i_guard_code      (i_guard_code),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_bitrate_100kbps (o_bitrate_100kbps)
    );

    always #5 i_clk = ~i_clk;

    // both channels sampled at the edge, before the nonblocking updates land
    always @(posedge i_clk) begin : sample_beats
        tb_rate_pkg::t_rate_desc seen;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            seen.rate_mode      = i_rate_mode;
            seen.mcs_index      = i_mcs_index;
            seen.legacy_rate    = i_legacy_rate;
            seen.stream_count   = i_stream_count;
            seen.bandwidth_code = i_bandwidth_code;
            seen.guard_code     = i_guard_code;
            sb.note_descriptor(seen);
        end
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_rate(o_bitrate_100kbps);
    end

    // output side: random stalls, or a solid hold-off while hold_active is set
    always @(posedge i_clk) begin
        if (hold_active)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // long hold-off: results back up until the block stops taking descriptors
    initial begin
        wait (phase == PH_PRESSURE);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d rates still pending", sb.pending());
        $display("DONE: errors detected");
        $finish;
    end

    function automatic tb_rate_pkg::t_rate_desc mk_desc(
        logic [wpr_pkg::MODE_W-1:0] mode, logic [wpr_pkg::FIELD_W-1:0] mcs,
        logic [wpr_pkg::LEGACY_W-1:0] legacy, logic [wpr_pkg::FIELD_W-1:0] streams,
        logic [wpr_pkg::FIELD_W-1:0] bw, logic [wpr_pkg::FIELD_W-1:0] gi);
        tb_rate_pkg::t_rate_desc d;
        d.rate_mode      = mode;
        d.mcs_index      = mcs;
        d.legacy_rate    = legacy;
        d.stream_count   = streams;
        d.bandwidth_code = bw;
        d.guard_code     = gi;
        return d;
    endfunction

    // mostly in-range descriptors per mode, some with one field pushed out
    // of range, the rest pure noise
    function automatic tb_rate_pkg::t_rate_desc rand_descriptor();
        tb_rate_pkg::t_rate_desc d;
        int                      kind;
        kind             = $urandom_range(99);
        d.rate_mode      = wpr_pkg::MODE_W'($urandom);
        d.mcs_index      = wpr_pkg::FIELD_W'($urandom);
        d.legacy_rate    = wpr_pkg::LEGACY_W'($urandom);
        d.stream_count   = wpr_pkg::FIELD_W'($urandom);
        d.bandwidth_code = wpr_pkg::FIELD_W'($urandom);
        d.guard_code     = wpr_pkg::FIELD_W'($urandom);
        if (kind < 90) begin
            case ($urandom_range(3))
                0: d.rate_mode = wpr_pkg::MODE_LEGACY;
                1: begin
                    d.rate_mode      = wpr_pkg::MODE_HT;
                    d.mcs_index      =
                        wpr_pkg::FIELD_W'($urandom_range(wpr_pkg::HT_MCS_MAX));
                    d.bandwidth_code =
                        wpr_pkg::FIELD_W'($urandom_range(wpr_pkg::HT_BW_MAX));
                end
                2: begin
                    d.rate_mode      = wpr_pkg::MODE_VHT;
                    d.mcs_index      =
                        wpr_pkg::FIELD_W'($urandom_range(wpr_pkg::VHT_MCS_MAX));
                    d.bandwidth_code =
                        wpr_pkg::FIELD_W'($urandom_range(wpr_pkg::BW_MAX));
                end
                default: begin
                    d.rate_mode      = wpr_pkg::MODE_HE;
                    d.mcs_index      =
                        wpr_pkg::FIELD_W'($urandom_range(wpr_pkg::HE_MCS_MAX));
                    d.bandwidth_code =
                        wpr_pkg::FIELD_W'($urandom_range(wpr_pkg::BW_MAX));
                    d.guard_code     =
                        wpr_pkg::FIELD_W'($urandom_range(wpr_pkg::HE_GI_MAX));
                end
            endcase
            // realistic stream counts half the time
            if ($urandom_range(1))
                d.stream_count = wpr_pkg::FIELD_W'($urandom_range(8));
            // long guard interval half the time for ht and vht
            if (d.rate_mode != wpr_pkg::MODE_HE && $urandom_range(1))
                d.guard_code = '0;
            if (kind >= 75) begin
                case ($urandom_range(2))
                    0:       d.mcs_index      = wpr_pkg::FIELD_W'($urandom);
                    1:       d.bandwidth_code = wpr_pkg::FIELD_W'($urandom);
                    default: d.guard_code     = wpr_pkg::FIELD_W'($urandom);
                endcase
            end
        end
        return d;
    endfunction

    // hold valid and payload until the beat is taken
    task send_descriptor(tb_rate_pkg::t_rate_desc d);
        i_in_valid       <= 1'b1;
        i_rate_mode      <= d.rate_mode;
        i_mcs_index      <= d.mcs_index;
        i_legacy_rate    <= d.legacy_rate;
        i_stream_count   <= d.stream_count;
        i_bandwidth_code <= d.bandwidth_code;
        i_guard_code     <= d.guard_code;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task run_phase(t_phase ph, int idle_pct, int stall, int count);
        phase     = ph;
        stall_pct <= stall;
        repeat (count) begin
            while ($urandom_range(99) < idle_pct) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            send_descriptor(rand_descriptor());
        end
    endtask

    initial begin
        tb_rate_pkg::t_rate_desc directed [$];
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // legacy passthrough extremes, other fields ignored
        directed.push_back(mk_desc(wpr_pkg::MODE_LEGACY, 8'hFF, 16'h0000, 8'hFF, 8'hFF, 8'hFF));
        directed.push_back(mk_desc(wpr_pkg::MODE_LEGACY, 8'h00, 16'hFFFF, 8'h00, 8'h00, 8'h00));
        // unknown modes
        directed.push_back(mk_desc(8'd4, 8'd0, 16'hFFFF, 8'd1, 8'd0, 8'd0));
        directed.push_back(mk_desc(8'hFF, 8'd5, 16'h1234, 8'd2, 8'd1, 8'd1));
        // ht: smallest and largest index, stream field ignored, out of range
        directed.push_back(mk_desc(wpr_pkg::MODE_HT, 8'd0, 16'hFFFF, 8'd0, 8'd0, 8'd0));
        directed.push_back(mk_desc(wpr_pkg::MODE_HT, 8'd31, 16'h0000, 8'hFF, 8'd1, 8'hFF));
        directed.push_back(mk_desc(wpr_pkg::MODE_HT, 8'd32, 16'h0000, 8'd1, 8'd0, 8'd0));
        directed.push_back(mk_desc(wpr_pkg::MODE_HT, 8'd12, 16'h0000, 8'd1, 8'd2, 8'd1));
        directed.push_back(mk_desc(wpr_pkg::MODE_HT, 8'hFF, 16'h0000, 8'd1, 8'hFF, 8'd0));
        // vht: 20 mhz long gi mcs 9 has no rate; also widest bandwidth, zero streams, out of range
        directed.push_back(mk_desc(wpr_pkg::MODE_VHT, 8'd9, 16'h0000, 8'd1, 8'd0, 8'd0));
        directed.push_back(mk_desc(wpr_pkg::MODE_VHT, 8'd9, 16'h0000, 8'd0, 8'd2, 8'd1));
        directed.push_back(mk_desc(wpr_pkg::MODE_VHT, 8'd9, 16'h0000, 8'hFF, 8'd2, 8'hFF));
        directed.push_back(mk_desc(wpr_pkg::MODE_VHT, 8'd0, 16'h0000, 8'd0, 8'd1, 8'd0));
        directed.push_back(mk_desc(wpr_pkg::MODE_VHT, 8'd10, 16'h0000, 8'd1, 8'd0, 8'd0));
        directed.push_back(mk_desc(wpr_pkg::MODE_VHT, 8'd3, 16'h0000, 8'd1, 8'd3, 8'd0));
        // he: largest result, zero streams, each range limit crossed
        directed.push_back(mk_desc(wpr_pkg::MODE_HE, 8'd11, 16'h0000, 8'hFF, 8'd2, 8'd2));
        directed.push_back(mk_desc(wpr_pkg::MODE_HE, 8'd0, 16'hFFFF, 8'd0, 8'd0, 8'd0));
        directed.push_back(mk_desc(wpr_pkg::MODE_HE, 8'd5, 16'h0000, 8'd3, 8'd1, 8'd1));
        directed.push_back(mk_desc(wpr_pkg::MODE_HE, 8'd12, 16'h0000, 8'd1, 8'd0, 8'd0));
        directed.push_back(mk_desc(wpr_pkg::MODE_HE, 8'd4, 16'h0000, 8'd1, 8'd3, 8'd0));
        directed.push_back(mk_desc(wpr_pkg::MODE_HE, 8'd4, 16'h0000, 8'd1, 8'd0, 8'd3));
        directed.push_back(mk_desc(wpr_pkg::MODE_HE, 8'hFF, 16'h0000, 8'hFF, 8'hFF, 8'hFF));

        foreach (directed[k])
            send_descriptor(directed[k]);

        run_phase(PH_FREE,           0,  0,  200);
        run_phase(PH_SENDER_IDLE,    66, 0,  200);
        run_phase(PH_RECEIVER_STALL, 0,  66, 200);
        run_phase(PH_BOTH,           13, 13, 200);
        run_phase(PH_PRESSURE,       0,  0,  130);

        i_in_valid <= 1'b0;
        stall_pct  <= 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("ran %0d rate descriptors over legacy, ht, vht, he and invalid modes",
                 sb.descriptors);
        $display("checked %0d rates under idle, stall and long output hold-off phases",
                 sb.rates_checked);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
